// ----- hdl/rational_arith_reduce_assert.svh -----
// Assertion macros for the rational arithmetic reduction block.
// Used by the port checker; depends on nothing else.
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH

// Clocked check that is switched off while reset is high.
`define RAR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rational_arith_reduce check failed");

// Clocked check that also holds across reset.
`define RAR_ASSERT_RESET(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rational_arith_reduce reset check failed");

`endif

// ----- hdl/rar_pkg.sv -----
// Shared widths, action codes and status type for the rational arithmetic block.
// Has no dependencies; every other file but the assertion header refers to it by scoped names.
package rar_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int SUM_WIDTH     = PROD_WIDTH + 1;
   localparam int MAG_WIDTH     = PROD_WIDTH;
   localparam int SUB_WIDTH     = MAG_WIDTH + 1;
   localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH);
   localparam int RESULT_WIDTH  = 32;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

endpackage

// ----- hdl/rar_sub.sv -----
// Shared subtract and compare unit of the rational arithmetic block.
// Serves both the binary GCD steps and the restoring division; uses rar_pkg.
module rar_sub (
   input  logic [rar_pkg::SUB_WIDTH-1:0] minuend,
   input  logic [rar_pkg::SUB_WIDTH-1:0] subtrahend,
   output logic [rar_pkg::SUB_WIDTH-1:0] difference,
   output logic                          borrow
);

   assign {borrow, difference} = {1'b0, minuend} - {1'b0, subtrahend};

endmodule

// ----- hdl/rar_core.sv -----
// Sequencer and datapath registers: products, combine, binary GCD, two divisions.
// Uses rar_pkg and instantiates the shared unit rar_sub.
module rar_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  rar_pkg::action_type                      action,
   input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] a,
   input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] b,
   input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] c,
   input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] d,
   input  logic                                     out_free,
   output rar_pkg::status_type                      status,
   output logic signed [rar_pkg::RESULT_WIDTH-1:0]  res_num,
   output logic signed [rar_pkg::RESULT_WIDTH-1:0]  res_den
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_COMBINE,
      S_GCD,
      S_DIV,
      S_SIGN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   rar_pkg::action_type act_ff, act_in;
   logic signed [rar_pkg::OPERAND_WIDTH-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic signed [rar_pkg::PROD_WIDTH-1:0] l_ff, l_in, r_ff, r_in, m_ff, m_in;
   logic neg_n_ff, neg_n_in, neg_m_ff, neg_m_in;
   logic [rar_pkg::MAG_WIDTH-1:0] mag_n_ff, mag_n_in, mag_m_ff, mag_m_in;
   logic [rar_pkg::MAG_WIDTH-1:0] x_ff, x_in, y_ff, y_in, g_ff, g_in, rem_ff, rem_in;
   logic [rar_pkg::SHIFT_WIDTH-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic div_m_ff, div_m_in;
   logic signed [rar_pkg::RESULT_WIDTH-1:0] res_num_ff, res_num_in, res_den_ff, res_den_in;

   logic signed [rar_pkg::OPERAND_WIDTH-1:0] mul_x, mul_y;
   logic signed [rar_pkg::PROD_WIDTH-1:0] prod;
   logic is_addsub;
   logic signed [rar_pkg::SUM_WIDTH-1:0] l_ext, r_ext, n_sum, n_neg;
   logic signed [rar_pkg::PROD_WIDTH-1:0] m_neg;
   logic [rar_pkg::SUB_WIDTH-1:0] sub_a, sub_b, sub_diff;
   logic sub_borrow;
   logic [rar_pkg::MAG_WIDTH-1:0] quo_cur, quo_next;
   logic signed [rar_pkg::MAG_WIDTH:0] qn_s, qm_s;

   rar_sub u_sub (
      .minuend    (sub_a),
      .subtrahend (sub_b),
      .difference (sub_diff),
      .borrow     (sub_borrow)
   );

   always_comb begin
      mul_x = a_ff;
      mul_y = d_ff;
      unique case (state_ff)
         S_MUL0: begin
            mul_y = (act_ff == rar_pkg::ACT_MUL) ? c_ff : d_ff;
         end
         S_MUL1: begin
            mul_x = c_ff;
            mul_y = b_ff;
         end
         S_MUL2: begin
            mul_x = b_ff;
            mul_y = (act_ff == rar_pkg::ACT_DIV) ? c_ff : d_ff;
         end
         default: begin
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   assign is_addsub = (act_ff == rar_pkg::ACT_ADD) || (act_ff == rar_pkg::ACT_SUB);
   assign l_ext     = rar_pkg::SUM_WIDTH'(l_ff);
   assign r_ext     = is_addsub ? rar_pkg::SUM_WIDTH'(r_ff) : '0;
   assign n_sum     = (act_ff == rar_pkg::ACT_SUB) ? (l_ext - r_ext) : (l_ext + r_ext);
   assign n_neg     = -n_sum;
   assign m_neg     = -m_ff;

   assign quo_cur  = div_m_ff ? mag_m_ff : mag_n_ff;
   assign quo_next = {quo_cur[rar_pkg::MAG_WIDTH-2:0], ~sub_borrow};

   always_comb begin
      if (state_ff == S_DIV) begin
         sub_a = {rem_ff, quo_cur[rar_pkg::MAG_WIDTH-1]};
         sub_b = {1'b0, g_ff};
      end else begin
         sub_a = {1'b0, x_ff};
         sub_b = {1'b0, y_ff};
      end
   end

   assign qn_s = neg_n_ff ? -$signed({1'b0, mag_n_ff}) : $signed({1'b0, mag_n_ff});
   assign qm_s = neg_m_ff ? -$signed({1'b0, mag_m_ff}) : $signed({1'b0, mag_m_ff});

   always_comb begin
      state_in   = state_ff;
      act_in     = act_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      d_in       = d_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      m_in       = m_ff;
      neg_n_in   = neg_n_ff;
      neg_m_in   = neg_m_ff;
      mag_n_in   = mag_n_ff;
      mag_m_in   = mag_m_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      g_in       = g_ff;
      rem_in     = rem_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      div_m_in   = div_m_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in = action;
               a_in   = a;
               b_in   = b;
               c_in   = c;
               d_in   = d;
               if (((action == rar_pkg::ACT_ADD) || (action == rar_pkg::ACT_SUB)) &&
                   (b == d)) begin
                  l_in     = rar_pkg::PROD_WIDTH'(a);
                  r_in     = rar_pkg::PROD_WIDTH'(c);
                  m_in     = rar_pkg::PROD_WIDTH'(b);
                  state_in = S_COMBINE;
               end else begin
                  state_in = S_MUL0;
               end
            end
         end
         S_MUL0: begin
            l_in     = prod;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            r_in     = prod;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            m_in     = prod;
            state_in = S_COMBINE;
         end
         S_COMBINE: begin
            neg_n_in = n_sum[rar_pkg::SUM_WIDTH-1];
            neg_m_in = m_ff[rar_pkg::PROD_WIDTH-1];
            mag_n_in = n_sum[rar_pkg::SUM_WIDTH-1] ? n_neg[rar_pkg::MAG_WIDTH-1:0]
                                                   : n_sum[rar_pkg::MAG_WIDTH-1:0];
            mag_m_in = m_ff[rar_pkg::PROD_WIDTH-1] ? m_neg[rar_pkg::MAG_WIDTH-1:0]
                                                   : m_ff[rar_pkg::MAG_WIDTH-1:0];
            x_in     = n_sum[rar_pkg::SUM_WIDTH-1] ? n_neg[rar_pkg::MAG_WIDTH-1:0]
                                                   : n_sum[rar_pkg::MAG_WIDTH-1:0];
            y_in     = m_ff[rar_pkg::PROD_WIDTH-1] ? m_neg[rar_pkg::MAG_WIDTH-1:0]
                                                   : m_ff[rar_pkg::MAG_WIDTH-1:0];
            k_in     = '0;
            if ((n_sum == '0) || (m_ff == '0)) begin
               res_num_in = rar_pkg::RESULT_WIDTH'(n_sum);
               res_den_in = rar_pkg::RESULT_WIDTH'(m_ff);
               state_in   = S_DONE;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            priority if (x_ff == '0) begin
               g_in     = y_ff << k_ff;
               rem_in   = '0;
               cnt_in   = '0;
               div_m_in = 1'b0;
               state_in = S_DIV;
            end else if (y_ff == '0) begin
               g_in     = x_ff << k_ff;
               rem_in   = '0;
               cnt_in   = '0;
               div_m_in = 1'b0;
               state_in = S_DIV;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + rar_pkg::SHIFT_WIDTH'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (sub_borrow) begin
               x_in = y_ff;
               y_in = x_ff;
            end else begin
               x_in = sub_diff[rar_pkg::MAG_WIDTH-1:0];
            end
         end
         S_DIV: begin
            rem_in = sub_borrow ? sub_a[rar_pkg::MAG_WIDTH-1:0]
                                : sub_diff[rar_pkg::MAG_WIDTH-1:0];
            if (div_m_ff) begin
               mag_m_in = quo_next;
            end else begin
               mag_n_in = quo_next;
            end
            cnt_in = cnt_ff + rar_pkg::SHIFT_WIDTH'(1);
            if (cnt_ff == rar_pkg::SHIFT_WIDTH'(rar_pkg::MAG_WIDTH - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               if (!div_m_ff) begin
                  div_m_in = 1'b1;
               end else begin
                  state_in = S_SIGN;
               end
            end
         end
         S_SIGN: begin
            res_num_in = rar_pkg::RESULT_WIDTH'(qn_s);
            res_den_in = rar_pkg::RESULT_WIDTH'(qm_s);
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      act_ff     <= act_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      d_ff       <= d_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      m_ff       <= m_in;
      neg_n_ff   <= neg_n_in;
      neg_m_ff   <= neg_m_in;
      mag_n_ff   <= mag_n_in;
      mag_m_ff   <= mag_m_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      g_ff       <= g_in;
      rem_ff     <= rem_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      div_m_ff   <= div_m_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
   end

   assign status.idle = (state_ff == S_IDLE);
   assign status.done = (state_ff == S_DONE);
   assign res_num     = res_num_ff;
   assign res_den     = res_den_ff;

endmodule

// ----- hdl/rational_arith_reduce.sv -----
// Top level of the rational arithmetic block: request intake and response register.
// Uses rar_pkg and instantiates rar_core.
//
// A request carries an action (add, subtract, multiply, divide) and two signed
// fractions. The response carries the result fraction reduced by the GCD of the
// magnitudes of its parts; if either raw part is zero it is sent unreduced.
// A request is taken when req_valid is high and req_stall is low. req_stall is
// high from the cycle after a request is taken until its result has moved into
// the response register, so one request is in work at a time.
// When a raw part is zero the result skips the GCD and the divisions; otherwise
// it passes the binary GCD steps on the shared subtractor, the step that finds
// the divisor included, and then the two 32-step divisions on the same
// subtractor; cross-multiplied add and subtract, multiply and divide first form
// the products on the single multiplier.
// The response register lets the next request be taken while a result waits.
// While rsp_stall is high a valid response holds, and a finished result waits in
// the core. Synchronous reset empties the response register and idles the core.
module rational_arith_reduce (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_action,
   input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] req_first_numerator,
   input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] req_first_denominator,
   input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] req_second_numerator,
   input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] req_second_denominator,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [rar_pkg::RESULT_WIDTH-1:0]  rsp_result_numerator,
   output logic signed [rar_pkg::RESULT_WIDTH-1:0]  rsp_result_denominator
);

   rar_pkg::status_type status;
   logic accept;
   logic out_free;
   logic signed [rar_pkg::RESULT_WIDTH-1:0] core_num, core_den;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [rar_pkg::RESULT_WIDTH-1:0] rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;

   assign req_stall = ~status.idle;
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   rar_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .action   (rar_pkg::action_type'(req_action)),
      .a        (req_first_numerator),
      .b        (req_first_denominator),
      .c        (req_second_numerator),
      .d        (req_second_denominator),
      .out_free (out_free),
      .status   (status),
      .res_num  (core_num),
      .res_den  (core_den)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      priority if (status.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_num_in   = core_num;
         rsp_den_in   = core_den;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_numerator   = rsp_num_ff;
   assign rsp_result_denominator = rsp_den_ff;

endmodule

// ----- hdl/rar_check.sv -----
// Port-level checker for the rational arithmetic block, bound to its top level.
// Depends on rational_arith_reduce_assert.svh and rar_pkg.
`include "rational_arith_reduce_assert.svh"

module rar_check (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [rar_pkg::RESULT_WIDTH-1:0] rsp_result_numerator,
   input logic signed [rar_pkg::RESULT_WIDTH-1:0] rsp_result_denominator
);

   logic                                  req_take;
   logic                                  rsp_hold;
   logic [2*rar_pkg::RESULT_WIDTH-1:0]    rsp_word;

   assign req_take = req_valid && !req_stall;
   assign rsp_hold = rsp_valid && rsp_stall;
   assign rsp_word = {rsp_result_numerator, rsp_result_denominator};

   `RAR_ASSERT_RESET(a_reset_clears, clock, reset |=> (!rsp_valid && !req_stall))

   `RAR_ASSERT(a_busy_after_request, clock, reset, req_take |=> req_stall)

   `RAR_ASSERT(a_min_latency, clock, reset, req_take |=> (!$rose(rsp_valid) ##1 !$rose(rsp_valid)))

   `RAR_ASSERT(a_response_holds, clock, reset, rsp_hold |=> (rsp_valid && $stable(rsp_word)))

endmodule

bind rational_arith_reduce rar_check u_rar_check (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_result_numerator   (rsp_result_numerator),
   .rsp_result_denominator (rsp_result_denominator)
);

// ----- tb/tb_rational_arith_reduce.sv -----
// Self-checking testbench for rational_arith_reduce: directed and random requests
// against a reduced-fraction predictor kept in a small ledger class.
// Depends on rar_pkg and on the rational_arith_reduce RTL only.

typedef logic signed [rar_pkg::OPERAND_WIDTH-1:0] operand_type;
typedef logic signed [rar_pkg::RESULT_WIDTH-1:0]  result_type;

typedef struct {
   int unsigned tag;
   result_type  numerator;
   result_type  denominator;
} owed_fraction_type;

class fraction_ledger;
   owed_fraction_type owed_fractions[$];
   int unsigned       requests_seen;
   int unsigned       responses_seen;
   int unsigned       mismatches;
   int unsigned       strays;
   int unsigned       per_action[4];
   int unsigned       zero_parts;
   int unsigned       shared_denominators;

   function int outstanding();
      return owed_fractions.size();
   endfunction

   function void note_request(rar_pkg::action_type act, operand_type a_in, operand_type b_in,
                              operand_type c_in, operand_type d_in);
      longint            a, b, c, d, top, bottom;
      longint unsigned   top_mag, bottom_mag, x, y, r;
      owed_fraction_type want;
      a = a_in;
      b = b_in;
      c = c_in;
      d = d_in;
      per_action[act]++;
      if ((act == rar_pkg::ACT_ADD || act == rar_pkg::ACT_SUB) && b == d) begin
         shared_denominators++;
         top    = (act == rar_pkg::ACT_ADD) ? a + c : a - c;
         bottom = b;
      end else if (act == rar_pkg::ACT_ADD) begin
         top    = a * d + c * b;
         bottom = b * d;
      end else if (act == rar_pkg::ACT_SUB) begin
         top    = a * d - c * b;
         bottom = b * d;
      end else if (act == rar_pkg::ACT_MUL) begin
         top    = a * c;
         bottom = b * d;
      end else begin
         top    = a * d;
         bottom = b * c;
      end
      if (top == 0 || bottom == 0) begin
         zero_parts++;
      end else begin
         // The divisor is found on magnitudes; each quotient keeps its own sign.
         top_mag    = (top < 0) ? -top : top;
         bottom_mag = (bottom < 0) ? -bottom : bottom;
         x = top_mag;
         y = bottom_mag;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         top    = (top < 0) ? -$signed(top_mag / x) : $signed(top_mag / x);
         bottom = (bottom < 0) ? -$signed(bottom_mag / x) : $signed(bottom_mag / x);
      end
      want.tag         = requests_seen;
      want.numerator   = 32'(top);
      want.denominator = 32'(bottom);
      owed_fractions.push_back(want);
      requests_seen++;
   endfunction

   function void check_response(result_type numerator, result_type denominator);
      owed_fraction_type want;
      responses_seen++;
      if (owed_fractions.size() == 0) begin
         strays++;
         if (mismatches + strays <= 10)
            $display("unexpected response %0d/%0d", numerator, denominator);
         return;
      end
      want = owed_fractions.pop_front();
      if (numerator !== want.numerator || denominator !== want.denominator) begin
         mismatches++;
         if (mismatches + strays <= 10)
            $display("request %0d: expected %0d/%0d, got %0d/%0d", want.tag,
                     want.numerator, want.denominator, numerator, denominator);
      end
   endfunction
endclass

module tb_rational_arith_reduce;

   localparam int RANDOM_REQUESTS = 1750;
   localparam int DRAIN_EVERY     = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = 400;
   localparam int FLAVOR_SMALL    = 0;
   localparam int FLAVOR_EXTREME  = 1;
   localparam int FLAVOR_FULL     = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = 2'd0;
   operand_type req_first_numerator = '0;
   operand_type req_first_denominator = '0;
   operand_type req_second_numerator = '0;
   operand_type req_second_denominator = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   result_type  rsp_result_numerator;
   result_type  rsp_result_denominator;

   fraction_ledger ledger = new;
   int             burst_left;
   int             idle_cycles;
   int             stall_mode;
   int             stall_left;
   int             failures;

   rational_arith_reduce dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_action             (req_action),
      .req_first_numerator    (req_first_numerator),
      .req_first_denominator  (req_first_denominator),
      .req_second_numerator   (req_second_numerator),
      .req_second_denominator (req_second_denominator),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result_numerator   (rsp_result_numerator),
      .rsp_result_denominator (rsp_result_denominator)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left <= 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(1, 60);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 0);
         2: rsp_stall <= ($urandom_range(0, 7) != 0);
         default: rsp_stall <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_valid && !req_stall)
            ledger.note_request(rar_pkg::action_type'(req_action), req_first_numerator,
                                req_first_denominator, req_second_numerator,
                                req_second_denominator);
         if (rsp_valid && !rsp_stall)
            ledger.check_response(rsp_result_numerator, rsp_result_denominator);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles", idle_cycles);
            $display("tb_rational_arith_reduce failed");
            $finish;
         end
      end
   end

   task automatic send_request(input rar_pkg::action_type act, input int a,
                               input int b, input int c, input int d);
      int gap;
      req_valid              <= 1'b1;
      req_action             <= act;
      req_first_numerator    <= operand_type'(a);
      req_first_denominator  <= operand_type'(b);
      req_second_numerator   <= operand_type'(c);
      req_second_denominator <= operand_type'(d);
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 10) : $urandom_range(1, 300);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.outstanding() != 0);
   endtask

   function automatic int pick_operand(int flavor);
      case (flavor)
         FLAVOR_SMALL: return int'($urandom_range(0, 24)) - 12;
         FLAVOR_EXTREME: begin
            case ($urandom_range(0, 5))
               0: return -32768;
               1: return -32767;
               2: return -1;
               3: return 0;
               4: return 1;
               default: return 32767;
            endcase
         end
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic random_request();
      rar_pkg::action_type act;
      int                  field[4];
      int                  kind;
      act  = rar_pkg::action_type'($urandom_range(0, 3));
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) begin
         if (kind < 4)
            field[i] = pick_operand(FLAVOR_FULL);
         else if (kind < 7)
            field[i] = pick_operand(FLAVOR_SMALL);
         else if (kind == 8)
            field[i] = pick_operand(FLAVOR_EXTREME);
         else
            field[i] = pick_operand($urandom_range(0, 2));
      end
      if ($urandom_range(0, 3) == 0)
         field[3] = field[1];
      if ($urandom_range(0, 15) == 0)
         field[$urandom_range(0, 3)] = 0;
      send_request(act, field[0], field[1], field[2], field[3]);
   endtask

   initial begin
      burst_left = $urandom_range(0, 30);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(rar_pkg::ACT_ADD, 1, 2, 1, 3);
      send_request(rar_pkg::ACT_ADD, 1, 4, 1, 4);
      send_request(rar_pkg::ACT_SUB, 3, 5, 3, 5);
      send_request(rar_pkg::ACT_MUL, 0, 7, 3, 9);
      send_request(rar_pkg::ACT_DIV, 2, 3, 0, 5);
      send_request(rar_pkg::ACT_ADD, 1, 0, 1, 0);
      send_request(rar_pkg::ACT_MUL, -32768, -32768, -32768, -32768);
      send_request(rar_pkg::ACT_DIV, 32767, -32768, -32768, 32767);
      send_request(rar_pkg::ACT_SUB, -32768, 1, 32767, -1);
      send_request(rar_pkg::ACT_ADD, 32767, 32767, 32767, -32768);
      send_request(rar_pkg::ACT_MUL, -1, 1, 1, -1);
      send_request(rar_pkg::ACT_DIV, -6, 4, 9, -15);
      send_request(rar_pkg::ACT_SUB, 5, -7, -3, -7);
      send_request(rar_pkg::ACT_ADD, -32768, -32768, -32768, -32768);
      send_request(rar_pkg::ACT_MUL, 32767, 1, 32767, 1);
      send_request(rar_pkg::ACT_DIV, 1, 32767, 1, -32768);
      send_request(rar_pkg::ACT_SUB, -1, -1, 1, 1);
      send_request(rar_pkg::ACT_ADD, 0, 1, 0, -1);
      send_request(rar_pkg::ACT_DIV, 0, 0, 0, 0);
      send_request(rar_pkg::ACT_MUL, 12, 18, 30, -45);
      send_request(rar_pkg::ACT_SUB, 7, 32767, -7, -32768);
      send_request(rar_pkg::ACT_ADD, -32767, 2, 32767, 3);
      drain_results();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
            drain_results();
         random_request();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      failures = ledger.mismatches + ledger.strays + ledger.outstanding();
      $display("Checked %0d responses for %0d requests (add %0d, sub %0d, mul %0d, div %0d).",
               ledger.responses_seen, ledger.requests_seen, ledger.per_action[0],
               ledger.per_action[1], ledger.per_action[2], ledger.per_action[3]);
      $display("%0d requests left a zero part, %0d took the shared denominator path.",
               ledger.zero_parts, ledger.shared_denominators);
      if (failures == 0) begin
         $display("tb_rational_arith_reduce passed");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing", ledger.mismatches,
                  ledger.strays, ledger.outstanding());
         $display("tb_rational_arith_reduce failed");
      end
      $finish;
   end

endmodule
